FILE: design/mpfu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Motor power feedback update package
// Shared constants, register indexes and structures for the power update.
// ----------------------------------------------------------------------------
package mpfu_pkg;

   localparam int unsigned SPEED_W    = 11;
   localparam int unsigned POWER_W    = 9;
   localparam int unsigned DUTY_W     = 8;
   localparam int unsigned THR_W      = 10;
   localparam int unsigned GAIN_W     = 10;
   localparam int unsigned DRIVE_W    = 22;
   localparam int unsigned INERTIA_W  = 19;
   localparam int unsigned NUM_W      = 24;
   localparam int unsigned QUOT_W     = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 10;

   localparam int INERTIA_GAIN = 240;
   localparam int PWR_SHIFT    = 8;
   localparam int PWR_SCALE    = 256;
   localparam int PWR_MAX      = 255;

   localparam logic [7:0]       FWD_RUN_RESET   = 8'd27;
   localparam logic [7:0]       FWD_START_RESET = 8'd73;
   localparam logic [9:0]       GAIN_RESET      = 10'd284;
   localparam logic signed [8:0] REV_RUN_RESET   = -9'sd27;
   localparam logic signed [8:0] REV_START_RESET = -9'sd73;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FWD_RUN_THR   = 3'd0,
      REG_FWD_START_THR = 3'd1,
      REG_FWD_SPEED     = 3'd2,
      REG_FWD_FEEDBACK  = 3'd3,
      REG_REV_RUN_THR   = 3'd4,
      REG_REV_START_THR = 3'd5,
      REG_REV_SPEED     = 3'd6,
      REG_REV_FEEDBACK  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [7:0]        fwd_run_thr;
      logic [7:0]        fwd_start_thr;
      logic [GAIN_W-1:0] fwd_speed_gain;
      logic [GAIN_W-1:0] fwd_feedback_gain;
      logic [8:0]        rev_run_thr;
      logic [8:0]        rev_start_thr;
      logic [GAIN_W-1:0] rev_speed_gain;
      logic [GAIN_W-1:0] rev_feedback_gain;
   } cfg_type;

   typedef struct packed {
      logic               req_zero;
      logic               forward;
      logic [THR_W-1:0]   thr;
      logic [DRIVE_W-1:0] drive;
   } drive_type;

endpackage
`default_nettype wire

FILE: design/motor_power_feedback_update_core.sv
`default_nettype none
// Pipeline: a request passes through the input, drive and output registers to its response.
// Throughput: one request per cycle while rsp_stall is low; the stored power is updated
// as each request leaves the drive register, so the next request sees it without a bubble.
// The drive register holds the chosen threshold and the difference of both speed products.
// Reset clears all valids, sets the stored power to zero and loads default thresholds and gains.
// ----------------------------------------------------------------------------
// Motor power feedback update core
// Updates a stored motor power from requested and measured wheel speed.
// ----------------------------------------------------------------------------
module motor_power_feedback_update_core (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic signed [mpfu_pkg::SPEED_W-1:0]       req_requested_speed,
   input  wire logic signed [mpfu_pkg::SPEED_W-1:0]       req_measured_speed,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic signed [mpfu_pkg::POWER_W-1:0]            rsp_power_level,
   output logic [mpfu_pkg::DUTY_W-1:0]                    rsp_forward_duty,
   output logic [mpfu_pkg::DUTY_W-1:0]                    rsp_backward_duty,
   input  wire logic                                      csr_write,
   input  wire logic [mpfu_pkg::CSR_IDX_W-1:0]            csr_index,
   input  wire logic [mpfu_pkg::CSR_DATA_W-1:0]           csr_data
);

   mpfu_pkg::cfg_type                       cfg;
   mpfu_pkg::drive_type                     drive_in;
   mpfu_pkg::drive_type                     drive_ff;

   logic                                    in_valid_ff;
   logic signed [mpfu_pkg::SPEED_W-1:0]     in_req_ff;
   logic signed [mpfu_pkg::SPEED_W-1:0]     in_meas_ff;
   logic                                    drive_valid_ff;
   logic                                    out_valid_ff;
   logic signed [mpfu_pkg::POWER_W-1:0]     out_power_ff;
   logic [mpfu_pkg::DUTY_W-1:0]             out_fwd_ff;
   logic [mpfu_pkg::DUTY_W-1:0]             out_bwd_ff;
   logic signed [mpfu_pkg::POWER_W-1:0]     power_ff;

   logic signed [mpfu_pkg::POWER_W-1:0]     power_in;
   logic [mpfu_pkg::DUTY_W-1:0]             fwd_in;
   logic [mpfu_pkg::DUTY_W-1:0]             bwd_in;

   logic                                    out_adv;
   logic                                    drive_adv;
   logic                                    in_adv;
   logic                                    in_valid_in;
   logic                                    drive_valid_in;
   logic                                    out_valid_in;

   mpfu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mpfu_drive u_drive (
      .cfg             (cfg),
      .requested_speed (in_req_ff),
      .measured_speed  (in_meas_ff),
      .drive           (drive_in)
   );

   mpfu_power u_power (
      .drive         (drive_ff),
      .current_power (power_ff),
      .power_level   (power_in),
      .forward_duty  (fwd_in),
      .backward_duty (bwd_in)
   );

   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign drive_adv = !drive_valid_ff || out_adv;
   assign in_adv    = !in_valid_ff || drive_adv;
   assign req_stall = !in_adv;

   assign in_valid_in    = in_adv ? req_valid : in_valid_ff;
   assign drive_valid_in = drive_adv ? in_valid_ff : drive_valid_ff;
   assign out_valid_in   = out_adv ? drive_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         drive_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         power_ff       <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         drive_valid_ff <= drive_valid_in;
         out_valid_ff   <= out_valid_in;
         if (drive_valid_ff && out_adv) begin
            power_ff <= power_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && req_valid) begin
         in_req_ff  <= req_requested_speed;
         in_meas_ff <= req_measured_speed;
      end
      if (drive_adv && in_valid_ff) begin
         drive_ff <= drive_in;
      end
      if (out_adv && drive_valid_ff) begin
         out_power_ff <= power_in;
         out_fwd_ff   <= fwd_in;
         out_bwd_ff   <= bwd_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_power_level   = out_power_ff;
   assign rsp_forward_duty  = out_fwd_ff;
   assign rsp_backward_duty = out_bwd_ff;

endmodule
`default_nettype wire

FILE: design/mpfu_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Motor power feedback update configuration registers
// Holds the thresholds and gains, written through a simple write port.
// ----------------------------------------------------------------------------
module mpfu_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write,
   input  wire logic [mpfu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mpfu_pkg::CSR_DATA_W-1:0]   csr_data,
   output mpfu_pkg::cfg_type                      cfg
);

   mpfu_pkg::cfg_type cfg_ff;
   mpfu_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (mpfu_pkg::reg_index_type'(csr_index))
            mpfu_pkg::REG_FWD_RUN_THR:   cfg_in.fwd_run_thr       = csr_data[7:0];
            mpfu_pkg::REG_FWD_START_THR: cfg_in.fwd_start_thr     = csr_data[7:0];
            mpfu_pkg::REG_FWD_SPEED:     cfg_in.fwd_speed_gain    = csr_data;
            mpfu_pkg::REG_FWD_FEEDBACK:  cfg_in.fwd_feedback_gain = csr_data;
            mpfu_pkg::REG_REV_RUN_THR:   cfg_in.rev_run_thr       = csr_data[8:0];
            mpfu_pkg::REG_REV_START_THR: cfg_in.rev_start_thr     = csr_data[8:0];
            mpfu_pkg::REG_REV_SPEED:     cfg_in.rev_speed_gain    = csr_data;
            mpfu_pkg::REG_REV_FEEDBACK:  cfg_in.rev_feedback_gain = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fwd_run_thr       <= mpfu_pkg::FWD_RUN_RESET;
         cfg_ff.fwd_start_thr     <= mpfu_pkg::FWD_START_RESET;
         cfg_ff.fwd_speed_gain    <= mpfu_pkg::GAIN_RESET;
         cfg_ff.fwd_feedback_gain <= mpfu_pkg::GAIN_RESET;
         cfg_ff.rev_run_thr       <= mpfu_pkg::REV_RUN_RESET;
         cfg_ff.rev_start_thr     <= mpfu_pkg::REV_START_RESET;
         cfg_ff.rev_speed_gain    <= mpfu_pkg::GAIN_RESET;
         cfg_ff.rev_feedback_gain <= mpfu_pkg::GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: design/mpfu_drive.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Motor power feedback update drive term
// Selects the direction threshold and forms gain*request - feedback*measured.
// ----------------------------------------------------------------------------
module mpfu_drive (
   input  wire mpfu_pkg::cfg_type                         cfg,
   input  wire logic signed [mpfu_pkg::SPEED_W-1:0]       requested_speed,
   input  wire logic signed [mpfu_pkg::SPEED_W-1:0]       measured_speed,
   output mpfu_pkg::drive_type                            drive
);

   logic                                      forward;
   logic                                      meas_zero;
   logic [mpfu_pkg::THR_W-1:0]                thr;
   logic [mpfu_pkg::GAIN_W-1:0]               speed_gain;
   logic [mpfu_pkg::GAIN_W-1:0]               feedback_gain;
   logic signed [mpfu_pkg::DRIVE_W-1:0]       req_term;
   logic signed [mpfu_pkg::DRIVE_W-1:0]       meas_term;

   always_comb begin
      forward   = !requested_speed[mpfu_pkg::SPEED_W-1];
      meas_zero = (measured_speed == '0);
      if (forward) begin
         thr = meas_zero ? {2'b00, cfg.fwd_start_thr} : {2'b00, cfg.fwd_run_thr};
         speed_gain    = cfg.fwd_speed_gain;
         feedback_gain = cfg.fwd_feedback_gain;
      end else begin
         thr = meas_zero ? {cfg.rev_start_thr[8], cfg.rev_start_thr}
                         : {cfg.rev_run_thr[8], cfg.rev_run_thr};
         speed_gain    = cfg.rev_speed_gain;
         feedback_gain = cfg.rev_feedback_gain;
      end
      req_term  = $signed({1'b0, speed_gain}) * requested_speed;
      meas_term = $signed({1'b0, feedback_gain}) * measured_speed;
   end

   assign drive.req_zero = (requested_speed == '0);
   assign drive.forward  = forward;
   assign drive.thr      = thr;
   assign drive.drive    = req_term - meas_term;

endmodule
`default_nettype wire

FILE: design/mpfu_power.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Motor power feedback update power stage
// Adds the inertia and threshold terms, divides by 256 toward zero, clamps and splits duties.
// ----------------------------------------------------------------------------
module mpfu_power (
   input  wire mpfu_pkg::drive_type                       drive,
   input  wire logic signed [mpfu_pkg::POWER_W-1:0]       current_power,
   output logic signed [mpfu_pkg::POWER_W-1:0]            power_level,
   output logic [mpfu_pkg::DUTY_W-1:0]                    forward_duty,
   output logic [mpfu_pkg::DUTY_W-1:0]                    backward_duty
);

   localparam logic signed [mpfu_pkg::INERTIA_W-1:0] INERTIA_K =
      mpfu_pkg::INERTIA_W'(mpfu_pkg::INERTIA_GAIN);
   localparam logic signed [mpfu_pkg::NUM_W-1:0] ROUND_BIAS =
      mpfu_pkg::NUM_W'(mpfu_pkg::PWR_SCALE - 1);
   localparam logic signed [mpfu_pkg::QUOT_W-1:0] POS_LIMIT =
      mpfu_pkg::QUOT_W'(mpfu_pkg::PWR_MAX);
   localparam logic signed [mpfu_pkg::QUOT_W-1:0] NEG_LIMIT =
      -mpfu_pkg::QUOT_W'(mpfu_pkg::PWR_MAX);

   logic signed [mpfu_pkg::THR_W-1:0]      thr;
   logic signed [mpfu_pkg::THR_W:0]        diff;
   logic signed [mpfu_pkg::INERTIA_W-1:0]  inertia;
   logic signed [mpfu_pkg::NUM_W-1:0]      num;
   logic signed [mpfu_pkg::NUM_W-1:0]      num_adj;
   logic signed [mpfu_pkg::QUOT_W-1:0]     quot;
   logic signed [mpfu_pkg::QUOT_W-1:0]     thr_q;
   logic signed [mpfu_pkg::QUOT_W-1:0]     bounded;
   logic signed [mpfu_pkg::POWER_W-1:0]    neg_power;

   always_comb begin
      thr     = $signed(drive.thr);
      diff    = (mpfu_pkg::THR_W+1)'(current_power) - (mpfu_pkg::THR_W+1)'(thr);
      inertia = mpfu_pkg::INERTIA_W'(diff) * INERTIA_K;
      num     = mpfu_pkg::NUM_W'($signed(drive.drive)) + mpfu_pkg::NUM_W'(inertia)
              + (mpfu_pkg::NUM_W'(thr) <<< mpfu_pkg::PWR_SHIFT);
      num_adj = num[mpfu_pkg::NUM_W-1] ? (num + ROUND_BIAS) : num;
      quot    = $signed(num_adj[mpfu_pkg::NUM_W-1:mpfu_pkg::PWR_SHIFT]);
      thr_q   = mpfu_pkg::QUOT_W'(thr);

      bounded = quot;
      if (drive.forward) begin
         if (quot < thr_q) begin
            bounded = thr_q;
         end
      end else begin
         if (quot > thr_q) begin
            bounded = thr_q;
         end
      end
      if (bounded > POS_LIMIT) begin
         bounded = POS_LIMIT;
      end
      if (bounded < NEG_LIMIT) begin
         bounded = NEG_LIMIT;
      end
      if (drive.req_zero) begin
         bounded = '0;
      end

      power_level   = bounded[mpfu_pkg::POWER_W-1:0];
      neg_power     = -power_level;
      forward_duty  = (power_level > 0) ? power_level[mpfu_pkg::DUTY_W-1:0] : '0;
      backward_duty = (power_level < 0) ? neg_power[mpfu_pkg::DUTY_W-1:0] : '0;
   end

endmodule
`default_nettype wire

FILE: design/mpfu_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Motor power feedback update checker
// Watches the response port for range, duty split and handshake behavior.
// ----------------------------------------------------------------------------
module mpfu_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_stall,
   input wire logic signed [mpfu_pkg::POWER_W-1:0]    rsp_power_level,
   input wire logic [mpfu_pkg::DUTY_W-1:0]            rsp_forward_duty,
   input wire logic [mpfu_pkg::DUTY_W-1:0]            rsp_backward_duty
);

   localparam logic signed [mpfu_pkg::POWER_W-1:0] NEG_LIMIT =
      -mpfu_pkg::POWER_W'(mpfu_pkg::PWR_MAX);

   // A stalled response stays valid and its power level unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_power_level))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_power_level >= NEG_LIMIT)
      else $error("power below negative limit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_power_level > 0 |->
         rsp_forward_duty == rsp_power_level[mpfu_pkg::DUTY_W-1:0] &&
         rsp_backward_duty == '0)
      else $error("forward duty does not match power");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_power_level <= 0 |->
         rsp_forward_duty == '0 &&
         rsp_backward_duty == mpfu_pkg::DUTY_W'(-rsp_power_level))
      else $error("backward duty does not match power");

   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind motor_power_feedback_update_core mpfu_checker u_checker (.*);
`default_nettype wire
